FILE: sv/hbcc_pkg.sv
// Package for the hash bucket collision counter.
// Holds the field widths, register indexes, reset values and bitmap row geometry.
// No dependencies.
package hbcc_pkg;

	localparam int SUM_W = 16;
	localparam int CODE_W = 8;
	localparam int BASE_W = 30;
	localparam int SIZE_W = 14;
	localparam int CNT_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_NUMBER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd1;

	localparam logic [BASE_W-1:0] BASE_RESET = 30'd5003;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd5000;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	localparam int TABLE_DEPTH_DEF = 8192;

	localparam int ROW_W = 32;
	localparam int ROW_SEL_W = 5;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

FILE: sv/hbcc_mod_unit.sv
// Iterative remainder unit: a 16-bit dividend modulo a 30-bit divisor.
// Restoring scheme, two dividend bits per cycle. Depends on hbcc_pkg.
module hbcc_mod_unit
	import hbcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [BASE_W-1:0] divisor,
	output logic              done,
	output logic [SUM_W-1:0]  remainder
);

	localparam int MOD_BITS = 2;
	localparam int STEPS = SUM_W / MOD_BITS;
	localparam int STEP_CNT_W = $clog2(STEPS);

	logic [SUM_W-1:0]      rem_q;
	logic [SUM_W-1:0]      dvd_q;
	logic [BASE_W-1:0]     div_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SUM_W-1:0]      rem_next;

	always_comb begin
		logic [BASE_W-1:0] trial;
		logic [SUM_W-1:0]  r;
		r = rem_q;
		trial = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			trial = BASE_W'({r, dvd_q[SUM_W-1-i]});
			if (trial >= div_q) begin
				trial = trial - div_q;
			end
			r = trial[SUM_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << MOD_BITS;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("remainder ready without a running division");
	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && step_q == '0) |=> done_q)
		else $error("final step did not signal completion");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && div_q != '0) |-> (BASE_W'(rem_q) < div_q))
		else $error("remainder not below divisor");
`endif

endmodule

FILE: sv/hbcc_occ_map.sv
// Bucket occupancy bitmap, stored as rows of ROW_W bits.
// One write port and one registered read port. Depends on hbcc_pkg.
module hbcc_occ_map
	import hbcc_pkg::*;
#(
	parameter int RA_W = 8
)
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [RA_W-1:0]  wr_addr,
	input  logic [ROW_W-1:0] wr_row,
	input  logic             rd_en,
	input  logic [RA_W-1:0]  rd_addr,
	output logic [ROW_W-1:0] rd_row
);

	logic [ROW_W-1:0] mem [2**RA_W];
	logic [ROW_W-1:0] rd_row_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	assign rd_row = rd_row_q;

endmodule

FILE: sv/hash_bucket_collision_counter.sv
// Channel    Signals                               Direction  Transfer
// in         in_valid/in_ready, kind, char_code,   input      in_valid && in_ready
//            end_of_word
// out        out_valid/out_ready, bucket,          output     out_valid && out_ready
//            collided, collision_count
// cfg        cfg_write, cfg_index, cfg_data        input      cfg_write
//
// A character that does not end a word leaves the input ready for the next item.
// A last character keeps the input busy after its transfer; the shared two-bits-per-cycle
// remainder unit runs twice, once when base_number is zero, then the bitmap is updated.
// Reset and every restart start a clearing pass over all 2**RA_W bitmap rows (256 at the
// default depth), during which no item is taken.
// A result waits in the output register without stalling the input; only the
// bitmap update of the next word waits for it to be taken.
// Top level of the hash bucket collision counter: sequencer, sums, count and config.
// Depends on hbcc_pkg, hbcc_mod_unit and hbcc_occ_map.
module hash_bucket_collision_counter
	import hbcc_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int BKT_W = $clog2(TABLE_DEPTH)
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [CODE_W-1:0]    char_code,
	input  logic                 end_of_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BKT_W-1:0]     bucket,
	output logic                 collided,
	output logic [CNT_W-1:0]     collision_count,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data
);

	localparam int ROWS = (TABLE_DEPTH + ROW_W - 1) / ROW_W;
	localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW_W = BKT_W + RA_W;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_CLEAR  = 3'd0;
	localparam logic [ST_W-1:0] S_IDLE   = 3'd1;
	localparam logic [ST_W-1:0] S_M1_GO  = 3'd2;
	localparam logic [ST_W-1:0] S_M1_RUN = 3'd3;
	localparam logic [ST_W-1:0] S_M2_GO  = 3'd4;
	localparam logic [ST_W-1:0] S_M2_RUN = 3'd5;
	localparam logic [ST_W-1:0] S_RD     = 3'd6;
	localparam logic [ST_W-1:0] S_UPD    = 3'd7;

	logic [ST_W-1:0]   state_q;
	logic [RA_W-1:0]   clr_q;
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  word_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [BKT_W-1:0]  out_bucket_q;
	logic              out_hit_q;
	logic [CNT_W-1:0]  out_cnt_q;

	logic              in_xfer;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_next;
	logic [BASE_W-1:0] eff_size;
	logic              mod_start;
	logic [BASE_W-1:0] mod_divisor;
	logic              mod_done;
	logic [SUM_W-1:0]  mod_rem;
	logic [BW_W-1:0]   bkt_wide;
	logic [RA_W-1:0]   row_addr;
	logic [ROW_SEL_W-1:0] bit_sel;
	logic [ROW_W-1:0]  rd_row;
	logic              hit;
	logic              upd_go;
	logic [CNT_W-1:0]  cnt_next;
	logic              map_wr_en;
	logic [RA_W-1:0]   map_wr_addr;
	logic [ROW_W-1:0]  map_wr_row;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;

	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(char_code);
	assign sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	assign eff_size = (size_q == '0 || BASE_W'(size_q) > BASE_W'(TABLE_DEPTH))
		? BASE_W'(TABLE_DEPTH) : BASE_W'(size_q);

	assign mod_start = (state_q == S_M1_GO && base_q != '0) || (state_q == S_M2_GO);
	assign mod_divisor = (state_q == S_M1_GO) ? base_q : eff_size;

	assign bkt_wide = BW_W'(bucket_q);
	assign row_addr = RA_W'(bkt_wide >> ROW_SEL_W);
	assign bit_sel = bkt_wide[ROW_SEL_W-1:0];

	assign hit = rd_row[bit_sel];
	assign upd_go = (state_q == S_UPD) && !(out_valid_q && !out_ready);
	assign cnt_next = (hit && cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		map_wr_en = 1'b0;
		map_wr_addr = row_addr;
		map_wr_row = rd_row | (ROW_W'(1) << bit_sel);
		if (state_q == S_CLEAR) begin
			map_wr_en = 1'b1;
			map_wr_addr = clr_q;
			map_wr_row = '0;
		end else if (upd_go && !hit) begin
			map_wr_en = 1'b1;
		end
	end

	hbcc_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (word_q),
		.divisor   (mod_divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	hbcc_occ_map #(
		.RA_W (RA_W)
	) u_map (
		.clk     (clk),
		.wr_en   (map_wr_en),
		.wr_addr (map_wr_addr),
		.wr_row  (map_wr_row),
		.rd_en   (state_q == S_RD),
		.rd_addr (row_addr),
		.rd_row  (rd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			size_q <= SIZE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASE_NUMBER: base_q <= cfg_data;
				REG_TABLE_SIZE: size_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						if (kind == KIND_RESTART) begin
							sum_q <= '0;
							cnt_q <= '0;
							clr_q <= '0;
							state_q <= S_CLEAR;
						end else if (end_of_word) begin
							sum_q <= '0;
							state_q <= S_M1_GO;
						end else begin
							sum_q <= sum_next;
						end
					end
				end
				S_M1_GO: state_q <= (base_q == '0) ? S_M2_GO : S_M1_RUN;
				S_M1_RUN: begin
					if (mod_done) begin
						state_q <= S_M2_GO;
					end
				end
				S_M2_GO: state_q <= S_M2_RUN;
				S_M2_RUN: begin
					if (mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_UPD;
				S_UPD: begin
					if (upd_go) begin
						cnt_q <= cnt_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && kind == KIND_CHAR && end_of_word) begin
			word_q <= sum_next;
		end else if (state_q == S_M1_RUN && mod_done) begin
			word_q <= mod_rem;
		end
		if (state_q == S_M2_RUN && mod_done) begin
			bucket_q <= BKT_W'(mod_rem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_bucket_q <= bucket_q;
			out_hit_q <= hit;
			out_cnt_q <= cnt_next;
		end
	end

	assign out_valid = out_valid_q;
	assign bucket = out_bucket_q;
	assign collided = out_hit_q;
	assign collision_count = out_cnt_q;

`ifndef NO_ASSERTIONS
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_UPD)
		else $error("result appeared without a bitmap update");
	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1 || cnt_q == '0))
		else $error("collision count moved by more than one");
	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (BASE_W'(bucket_q) < eff_size))
		else $error("bucket beyond the table size");
`endif

endmodule

FILE: tb/sv/hbcc_bucket_checker.sv
// Result checker for the hash bucket collision counter testbench.
// Tracks register writes and input transfers, predicts each word's bucket, flag and count,
// and compares output transfers in order. Depends on hbcc_pkg.
`timescale 1ns / 100ps
module hbcc_bucket_checker
	import hbcc_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	localparam int BKT_W = $clog2(DEPTH)
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 kind,
	input  logic [CODE_W-1:0]    char_code,
	input  logic                 end_of_word,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BKT_W-1:0]     bucket,
	input  logic                 collided,
	input  logic [CNT_W-1:0]     collision_count,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   words_outstanding,
	output int                   words_checked,
	output int                   collisions_seen
);

	typedef struct packed {
		logic [BKT_W-1:0] bucket;
		logic             collided;
		logic [CNT_W-1:0] count;
	} word_result_t;

	word_result_t      expected_words[$];
	logic [BASE_W-1:0] base_number;
	logic [SIZE_W-1:0] table_size;
	logic [SUM_W-1:0]  char_sum;
	logic [CNT_W-1:0]  collisions;
	logic [DEPTH-1:0]  occupied;

	function automatic logic [BKT_W-1:0] bucket_of_sum(input logic [SUM_W-1:0] sum);
		longint unsigned reduced;
		longint unsigned buckets;
		reduced = 64'(sum);
		if (base_number != '0)
			reduced = reduced % 64'(base_number);
		buckets = 64'(table_size);
		if (table_size == '0 || buckets > 64'(DEPTH))
			buckets = 64'(DEPTH);
		return BKT_W'(reduced % buckets);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_result_t     want;
		logic [SUM_W:0]   wide_sum;
		int               bad;
		int               hits;
		int               done;
		bad = 0;
		hits = 0;
		done = 0;
		if (!arst_n) begin
			expected_words.delete();
			base_number = BASE_RESET;
			table_size = SIZE_RESET;
			char_sum = '0;
			collisions = '0;
			occupied = '0;
			mismatches <= 0;
			words_outstanding <= 0;
			words_checked <= 0;
			collisions_seen <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_BASE_NUMBER)
					base_number = cfg_data;
				else if (cfg_index == REG_TABLE_SIZE)
					table_size = cfg_data[SIZE_W-1:0];
			end

			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result: expected none, got bucket %0d",
						$time, bucket);
					bad++;
				end else begin
					want = expected_words.pop_front();
					done = 1;
					if (want.collided)
						hits = 1;
					if (bucket !== want.bucket) begin
						$display("%0t: bucket expected %0d, got %0d", $time, want.bucket, bucket);
						bad++;
					end
					if (collided !== want.collided) begin
						$display("%0t: collided expected %0d, got %0d",
							$time, want.collided, collided);
						bad++;
					end
					if (collision_count !== want.count) begin
						$display("%0t: collision_count expected %0d, got %0d",
							$time, want.count, collision_count);
						bad++;
					end
				end
			end

			if (in_valid && in_ready) begin
				if (kind == KIND_RESTART) begin
					occupied = '0;
					collisions = '0;
					char_sum = '0;
				end else begin
					wide_sum = {1'b0, char_sum} + (SUM_W + 1)'(char_code);
					char_sum = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
					if (end_of_word) begin
						want.bucket = bucket_of_sum(char_sum);
						want.collided = occupied[want.bucket];
						if (want.collided) begin
							if (collisions != CNT_MAX)
								collisions = collisions + 1'b1;
						end else begin
							occupied[want.bucket] = 1'b1;
						end
						want.count = collisions;
						expected_words.push_back(want);
						char_sum = '0;
					end
				end
			end

			mismatches <= mismatches + bad;
			words_checked <= words_checked + done;
			collisions_seen <= collisions_seen + hits;
			words_outstanding <= expected_words.size();
		end
	end

endmodule

FILE: tb/sv/tb_hash_bucket_collision_counter.sv
// Top of the hash bucket collision counter testbench: clock, reset, stimulus and verdict.
// Drives characters, words and restarts under several register settings with random idling.
// Depends on hbcc_pkg, hash_bucket_collision_counter and hbcc_bucket_checker.
`timescale 1ns / 100ps
module tb_hash_bucket_collision_counter;
	import hbcc_pkg::*;

	localparam int BKT_W = $clog2(TABLE_DEPTH_DEF);
	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_WORD = 12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 kind = KIND_CHAR;
	logic [CODE_W-1:0]    char_code = '0;
	logic                 end_of_word = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BKT_W-1:0]     bucket;
	logic                 collided;
	logic [CNT_W-1:0]     collision_count;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_BASE_NUMBER;
	logic [BASE_W-1:0]    cfg_data = '0;

	int mismatches;
	int words_outstanding;
	int words_checked;
	int collisions_seen;

	logic              idling = 1'b0;
	int                stall_left = 0;
	int                quiet_cycles = 0;
	int                chars_sent = 0;
	int                restarts_sent = 0;
	int                settings_used = 1;
	logic [CODE_W-1:0] last_word [MAX_WORD];
	int                last_len = 0;

	always #6 clk = ~clk;

	hash_bucket_collision_counter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.char_code       (char_code),
		.end_of_word     (end_of_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bucket          (bucket),
		.collided        (collided),
		.collision_count (collision_count),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	hbcc_bucket_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.kind              (kind),
		.char_code         (char_code),
		.end_of_word       (end_of_word),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.bucket            (bucket),
		.collided          (collided),
		.collision_count   (collision_count),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.words_outstanding (words_outstanding),
		.words_checked     (words_checked),
		.collisions_seen   (collisions_seen)
	);

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// A hang shows up as a long run of cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("hash_bucket_collision_counter: mismatch");
			$finish;
		end
	end

	task automatic send_item(input logic k, input logic [CODE_W-1:0] code, input logic last);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		char_code <= code;
		end_of_word <= last;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		if (k == KIND_RESTART)
			restarts_sent++;
		else
			chars_sent++;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CODE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_word(input int len);
		logic [CODE_W-1:0] code;
		for (int i = 0; i < len; i++) begin
			code = pick_code();
			last_word[i] = code;
			send_item(KIND_CHAR, code, i == len - 1);
		end
		last_len = len;
	endtask

	task automatic resend_word();
		if (last_len == 0)
			send_word(1);
		else
			for (int i = 0; i < last_len; i++)
				send_item(KIND_CHAR, last_word[i], i == last_len - 1);
	endtask

	task automatic send_restart();
		send_item(KIND_RESTART, CODE_W'($urandom), 1'($urandom));
	endtask

	task automatic random_traffic(input int count);
		int start;
		int roll;
		start = chars_sent + restarts_sent;
		while (chars_sent + restarts_sent - start < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				send_restart();
			end else if (roll < 8) begin
				repeat ($urandom_range(1, 4))
					send_item(KIND_CHAR, pick_code(), 1'b0);
				send_restart();
			end else if (roll < 25) begin
				resend_word();
			end else if (roll < 32) begin
				send_word($urandom_range(5, MAX_WORD));
			end else begin
				send_word($urandom_range(1, 4));
			end
		end
	endtask

	// Registers change only once every word has come out and any clearing pass is over.
	task automatic set_registers(input logic [BASE_W-1:0] base,
		input logic [BASE_W-1:0] size_word);
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_BASE_NUMBER;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= REG_TABLE_SIZE;
		cfg_data <= size_word;
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(KIND_CHAR, 8'd0, 1'b1);
		send_item(KIND_CHAR, 8'd0, 1'b1);
		send_item(KIND_CHAR, 8'd255, 1'b1);
		repeat (2) begin
			send_item(KIND_CHAR, 8'd97, 1'b0);
			send_item(KIND_CHAR, 8'd98, 1'b0);
			send_item(KIND_CHAR, 8'd99, 1'b1);
		end
		send_item(KIND_CHAR, 8'd200, 1'b0);
		send_item(KIND_CHAR, 8'd200, 1'b0);
		send_item(KIND_RESTART, 8'hFF, 1'b1);
		send_item(KIND_CHAR, 8'd0, 1'b1);
		send_item(KIND_RESTART, 8'h00, 1'b0);
		send_item(KIND_CHAR, 8'd5, 1'b0);
		send_item(KIND_CHAR, 8'd255, 1'b1);

		idling <= 1'b1;
		set_registers('0, '0);
		repeat (257) send_item(KIND_CHAR, '1, 1'b0);
		send_item(KIND_CHAR, '1, 1'b1);
		random_traffic(110);

		set_registers(30'd1, 30'd1);
		random_traffic(120);

		set_registers('1, {16'($urandom), 14'd8192});
		random_traffic(120);

		set_registers(BASE_W'($urandom_range(2, 200)),
			{16'($urandom), 14'($urandom_range(1, 64))});
		random_traffic(120);

		set_registers(BASE_W'($urandom_range(1, 30'h3FFF_FFFF)), {16'($urandom), 14'h3FFF});
		random_traffic(110);

		idling <= 1'b0;
		set_registers(BASE_RESET, BASE_W'(SIZE_RESET));
		random_traffic(120);

		in_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d characters and %0d restarts across %0d register settings.",
			chars_sent, restarts_sent, settings_used);
		$display("Checked %0d finished words, %0d of them in an occupied bucket.",
			words_checked, collisions_seen);
		if (mismatches == 0)
			$display("hash_bucket_collision_counter: match");
		else
			$display("hash_bucket_collision_counter: mismatch");
		$finish;
	end

endmodule

FILE: hash_bucket_collision_counter.f
sv/hbcc_pkg.sv
sv/hbcc_mod_unit.sv
sv/hbcc_occ_map.sv
sv/hash_bucket_collision_counter.sv
tb/sv/hbcc_bucket_checker.sv
tb/sv/tb_hash_bucket_collision_counter.sv
